### src/hgtc_pkg.sv
`timescale 1ns / 1ps
package hgtc_pkg;

  localparam int CoordW     = 16;
  localparam int CellW      = CoordW + 1;
  localparam int ValW       = 24;
  localparam int MagW       = ValW - 1;
  localparam int RecipShift = 29;
  localparam int RecipW     = 25;
  localparam int ProdW      = MagW + RecipW;
  localparam int QuoW       = ProdW - RecipShift;
  localparam int RemW       = 6;

  localparam int HashCount  = 5;
  localparam int CellCount  = 5;
  localparam int StageCount = 7;

  localparam int HashPrime [HashCount] = '{23, 29, 31, 37, 41};
  localparam int HashKr    [HashCount] = '{53, 67, 79, 89, 101};
  localparam int HashKc    [HashCount] = '{97, 41, 61, 71, 83};

  localparam longint RecipOne = longint'(1) << RecipShift;
  localparam longint HashRecip [HashCount] = '{
    (RecipOne + HashPrime[0] - 1) / HashPrime[0],
    (RecipOne + HashPrime[1] - 1) / HashPrime[1],
    (RecipOne + HashPrime[2] - 1) / HashPrime[2],
    (RecipOne + HashPrime[3] - 1) / HashPrime[3],
    (RecipOne + HashPrime[4] - 1) / HashPrime[4]
  };

  // centre first, then up, left, down, right
  localparam int CellDr [CellCount] = '{0, -1, 0, 1, 0};
  localparam int CellDc [CellCount] = '{0, 0, -1, 0, 1};

  typedef enum logic [1:0] {
    ClassGrass = 2'd0,
    ClassTree  = 2'd1,
    ClassSwamp = 2'd2
  } terrain_t;

  typedef logic [StageCount-1:0] stage_en_t;

  // class of a non-negative xor value below 64, taken modulo 17
  function automatic terrain_t raw_of(input logic [RemW-1:0] x);
    terrain_t c;
    case (x)
      6'd1, 6'd18, 6'd35, 6'd52: c = ClassTree;
      6'd2, 6'd19, 6'd36, 6'd53: c = ClassSwamp;
      default:                   c = ClassGrass;
    endcase
    return c;
  endfunction

endpackage

### src/hashed_grid_terrain_classifier_unit.sv
// Terrain classifier for a signed 16-bit grid cell. Each beat carries a row and a column and
// gives one terrain class (0 grass, 1 tree, 2 swamp) built from hashed raw classes of the cell
// and its four orthogonal neighbours. The seven-stage pipeline takes a new beat every clock
// cycle while no output stall holds it back; the stage depth is set by the reciprocal
// multiply that stands in for each prime remainder. Results leave in input order and an
// output stall holds the pipeline back without losing or repeating any beat.
`timescale 1ns / 1ps
module hashed_grid_terrain_classifier_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hgtc_pkg::CoordW-1:0] row_coord,
  input  logic signed [hgtc_pkg::CoordW-1:0] col_coord,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         terrain_class
);
  import hgtc_pkg::*;

  stage_en_t               en;
  logic signed [CoordW-1:0] row0, col0;
  logic signed [CellW-1:0]  cell_row [CellCount];
  logic signed [CellW-1:0]  cell_col [CellCount];
  terrain_t                 raw [CellCount];
  terrain_t                 class_next;
  logic                     any_tree, any_swamp;

  hgtc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      row0 <= row_coord;
      col0 <= col_coord;
    end
  end

  for (genvar k = 0; k < CellCount; k++) begin : g_cell
    assign cell_row[k] = CellW'(row0) + CellW'(CellDr[k]);
    assign cell_col[k] = CellW'(col0) + CellW'(CellDc[k]);

    hgtc_cell_class u_cell (
      .clk (clk),
      .en  (en),
      .row (cell_row[k]),
      .col (cell_col[k]),
      .raw (raw[k])
    );
  end

  // own swamp does not count, only a neighbour's
  always_comb begin
    any_tree  = 1'b0;
    any_swamp = 1'b0;
    for (int k = 0; k < CellCount; k++) begin
      if (raw[k] == ClassTree) begin
        any_tree = 1'b1;
      end
      if (k != 0 && raw[k] == ClassSwamp) begin
        any_swamp = 1'b1;
      end
    end
    if (any_tree) begin
      class_next = ClassTree;
    end else if (any_swamp) begin
      class_next = ClassSwamp;
    end else begin
      class_next = ClassGrass;
    end
  end

  always_ff @(posedge clk) begin
    if (en[StageCount-1]) begin
      terrain_class <= class_next;
    end
  end

endmodule

### src/hgtc_pipe_ctrl.sv
`timescale 1ns / 1ps
module hgtc_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output hgtc_pkg::stage_en_t en
);
  import hgtc_pkg::*;

  logic [StageCount-1:0] vld;

  always_comb begin
    en[StageCount-1] = !vld[StageCount-1] || out_ready;
    for (int k = StageCount - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < StageCount; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[StageCount-1];

endmodule

### src/hgtc_cell_class.sv
`timescale 1ns / 1ps
module hgtc_cell_class (
  input  logic                              clk,
  input  hgtc_pkg::stage_en_t               en,
  input  logic signed [hgtc_pkg::CellW-1:0] row,
  input  logic signed [hgtc_pkg::CellW-1:0] col,
  output hgtc_pkg::terrain_t                raw
);
  import hgtc_pkg::*;

  logic signed [ValW-1:0] v1   [HashCount];
  logic [MagW-1:0]        mag2 [HashCount];
  logic                   neg2 [HashCount];
  logic [QuoW-1:0]        quo3 [HashCount];
  logic [MagW-1:0]        mag3 [HashCount];
  logic                   neg3 [HashCount];
  logic [RemW-1:0]        rem4 [HashCount];
  logic                   neg4 [HashCount];

  for (genvar h = 0; h < HashCount; h++) begin : g_hash
    logic signed [ValW-1:0] row_x, col_x, kr, kc, v_next;
    logic [ValW-1:0]        v_neg;
    logic [ProdW-1:0]       prod;
    logic [MagW-1:0]        qp, rem_full;

    assign row_x  = ValW'(row);
    assign col_x  = ValW'(col);
    assign kr     = ValW'(HashKr[h]);
    assign kc     = ValW'(HashKc[h]);
    assign v_next = row_x * kr + col_x * kc;

    assign v_neg  = -v1[h];
    assign prod   = {{MagW{1'b0}}, RecipW'(HashRecip[h])} * {{RecipW{1'b0}}, mag2[h]};
    assign qp     = MagW'({{(MagW-QuoW){1'b0}}, quo3[h]} * MagW'(HashPrime[h]));
    assign rem_full = mag3[h] - qp;

    always_ff @(posedge clk) begin
      if (en[1]) begin
        v1[h] <= v_next;
      end
      if (en[2]) begin
        mag2[h] <= v1[h][ValW-1] ? v_neg[MagW-1:0] : v1[h][MagW-1:0];
        neg2[h] <= v1[h][ValW-1];
      end
      if (en[3]) begin
        quo3[h] <= prod[ProdW-1:RecipShift];
        mag3[h] <= mag2[h];
        neg3[h] <= neg2[h];
      end
      if (en[4]) begin
        rem4[h] <= rem_full[RemW-1:0];
        neg4[h] <= neg3[h];
      end
    end
  end

  logic [RemW-1:0] x_low;
  logic            x_neg;
  terrain_t        raw_next;

  // sign bits above the low six cancel unless an odd count is negative
  always_comb begin
    x_low = '0;
    x_neg = 1'b0;
    for (int h = 0; h < HashCount; h++) begin
      if (neg4[h] && rem4[h] != '0) begin
        x_low = x_low ^ (~rem4[h] + RemW'(1));
        x_neg = ~x_neg;
      end else begin
        x_low = x_low ^ rem4[h];
      end
    end
    raw_next = x_neg ? ClassGrass : raw_of(x_low);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      raw <= raw_next;
    end
  end

endmodule

### verif/hashed_grid_terrain_classifier_unit_tb.sv
`timescale 1ns / 1ps
module hashed_grid_terrain_classifier_unit_tb;
  import hgtc_pkg::terrain_t;
  import hgtc_pkg::ClassGrass;
  import hgtc_pkg::ClassTree;
  import hgtc_pkg::ClassSwamp;

  localparam int RandomItems = 1400;
  localparam int CycleLimit  = 400000;
  localparam int DrainWait   = 16;
  localparam int ReportCap   = 40;
  localparam int SeekSpan    = 64;

  localparam int HashMulRow [5] = '{53, 67, 79, 89, 101};
  localparam int HashMulCol [5] = '{97, 41, 61, 71, 83};
  localparam int HashMod    [5] = '{23, 29, 31, 37, 41};
  localparam int ClassMod       = 17;

  typedef enum int {
    SeekOwnSwamp,
    SeekCentreTree,
    SeekNeighbourTree,
    SeekNeighbourSwamp,
    SeekNegativeXor
  } seek_t;

  typedef enum int {
    StallNone,
    StallRandom,
    StallSparse,
    StallLong
  } stall_t;

  typedef struct {
    logic signed [15:0] row;
    logic signed [15:0] col;
    terrain_t           cls;
  } terrain_beat_t;

  typedef struct {
    logic signed [15:0] row;
    logic signed [15:0] col;
    bit                 typed;
    terrain_t           cls;
  } probe_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] row_coord = '0;
  logic signed [15:0] col_coord = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         terrain_class;

  terrain_beat_t pending_terrain [$];
  probe_t        probe_table [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            stall_tick = 0;
  stall_t        stall_mode = StallNone;

  hashed_grid_terrain_classifier_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .row_coord     (row_coord),
    .col_coord     (col_coord),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .terrain_class (terrain_class)
  );

  always #4 clk = ~clk;

  function automatic int hash_xor(input int r, input int c);
    int acc;
    acc = 0;
    for (int i = 0; i < 5; i++) begin
      acc ^= (r * HashMulRow[i] + c * HashMulCol[i]) % HashMod[i];
    end
    return acc;
  endfunction

  function automatic terrain_t cell_kind(input int r, input int c);
    int x;
    x = hash_xor(r, c);
    if (x < 0) begin
      return ClassGrass;
    end
    case (x % ClassMod)
      1:       return ClassTree;
      2:       return ClassSwamp;
      default: return ClassGrass;
    endcase
  endfunction

  function automatic terrain_t predict_terrain(input logic signed [15:0] row,
                                               input logic signed [15:0] col);
    int       r;
    int       c;
    bit       swamp_seen;
    terrain_t k;
    r = int'(row);
    c = int'(col);
    swamp_seen = 1'b0;
    if (cell_kind(r, c) == ClassTree) begin
      return ClassTree;
    end
    for (int i = 0; i < 4; i++) begin
      k = cell_kind(r + ((i == 0) ? -1 : (i == 2) ? 1 : 0),
                    c + ((i == 1) ? -1 : (i == 3) ? 1 : 0));
      if (k == ClassTree) begin
        return ClassTree;
      end
      if (k == ClassSwamp) begin
        swamp_seen = 1'b1;
      end
    end
    return swamp_seen ? ClassSwamp : ClassGrass;
  endfunction

  // first cell near the origin that shows the wanted behaviour
  function automatic bit seek_cell(input seek_t what, output logic signed [15:0] r_o,
                                   output logic signed [15:0] c_o);
    bit       hit;
    terrain_t centre;
    terrain_t final_cls;
    r_o = '0;
    c_o = '0;
    for (int r = -SeekSpan; r < SeekSpan; r++) begin
      for (int c = -SeekSpan; c < SeekSpan; c++) begin
        centre    = cell_kind(r, c);
        final_cls = predict_terrain(16'(r), 16'(c));
        case (what)
          SeekOwnSwamp:       hit = centre == ClassSwamp && final_cls == ClassGrass;
          SeekCentreTree:     hit = centre == ClassTree;
          SeekNeighbourTree:  hit = centre != ClassTree && final_cls == ClassTree;
          SeekNeighbourSwamp: hit = centre != ClassSwamp && final_cls == ClassSwamp;
          default:            hit = hash_xor(r, c) < 0;
        endcase
        if (hit) begin
          r_o = 16'(r);
          c_o = 16'(c);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic signed [15:0] coord_sample(input int pick);
    case (pick)
      0, 1, 2, 3, 4: return 16'($urandom);
      5, 6:          return 16'($urandom_range(0, 100) - 50);
      7:             return 16'(32767 - $urandom_range(0, 3));
      default:       return 16'(-32768 + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < ReportCap) begin
      $display("mismatch: %s", what);
    end
    mismatch_count++;
  endtask

  task automatic send_coord(input logic signed [15:0] r, input logic signed [15:0] c,
                            input terrain_t cls);
    terrain_beat_t b;
    in_valid  <= 1'b1;
    row_coord <= r;
    col_coord <= c;
    do @(posedge clk); while (!in_ready);
    b.row = r;
    b.col = c;
    b.cls = cls;
    pending_terrain.push_back(b);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // receiver stalls, in one of four patterns picked at random
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 50 == 0) begin
      stall_mode <= stall_t'($urandom_range(0, 3));
    end
    case (stall_mode)
      StallNone:   out_ready <= 1'b1;
      StallRandom: out_ready <= 1'($urandom_range(0, 1));
      StallSparse: out_ready <= (stall_tick % 4 == 0);
      default:     out_ready <= (stall_tick % 13 >= 10);
    endcase
  end

  always @(posedge clk) begin
    terrain_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_terrain.size() == 0) begin
        report_mismatch($sformatf("terrain_class %0d with nothing pending", terrain_class));
      end else begin
        want = pending_terrain.pop_front();
        if (terrain_class !== want.cls) begin
          report_mismatch($sformatf("terrain_class got %0d want %0d at row %0d col %0d",
                                    terrain_class, want.cls, want.row, want.col));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    probe_t             p;
    logic signed [15:0] sr;
    logic signed [15:0] sc;
    int                 sent;
    int                 burst;
    bit                 drained;

    // extremes and corners, all checked against the predictor
    p.typed = 1'b0;
    p.cls   = ClassGrass;
    p.row = 16'sd0;      p.col = 16'sd0;      probe_table.push_back(p);
    p.row = 16'sd32767;  p.col = 16'sd32767;  probe_table.push_back(p);
    p.row = -16'sd32768; p.col = -16'sd32768; probe_table.push_back(p);
    p.row = 16'sd32767;  p.col = -16'sd32768; probe_table.push_back(p);
    p.row = -16'sd32768; p.col = 16'sd32767;  probe_table.push_back(p);
    p.row = 16'sd0;      p.col = 16'sd32767;  probe_table.push_back(p);
    p.row = -16'sd32768; p.col = 16'sd0;      probe_table.push_back(p);
    p.row = 16'sd32767;  p.col = 16'sd0;      probe_table.push_back(p);
    p.row = 16'sd0;      p.col = -16'sd32768; probe_table.push_back(p);
    p.row = 16'sd1;      p.col = -16'sd1;     probe_table.push_back(p);
    p.row = -16'sd1;     p.col = 16'sd1;      probe_table.push_back(p);
    p.row = -16'sd1;     p.col = -16'sd1;     probe_table.push_back(p);
    p.row = 16'sd1;      p.col = 16'sd1;      probe_table.push_back(p);
    // special cases found near the origin
    if (seek_cell(SeekOwnSwamp, sr, sc)) begin
      p.row = sr; p.col = sc; p.typed = 1'b1; p.cls = ClassGrass;
      probe_table.push_back(p);
    end
    if (seek_cell(SeekCentreTree, sr, sc)) begin
      p.row = sr; p.col = sc; p.typed = 1'b1; p.cls = ClassTree;
      probe_table.push_back(p);
    end
    p.typed = 1'b0;
    if (seek_cell(SeekNeighbourTree, sr, sc)) begin
      p.row = sr; p.col = sc; probe_table.push_back(p);
    end
    if (seek_cell(SeekNeighbourSwamp, sr, sc)) begin
      p.row = sr; p.col = sc; probe_table.push_back(p);
    end
    if (seek_cell(SeekNegativeXor, sr, sc)) begin
      p.row = sr; p.col = sc; probe_table.push_back(p);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_table[i]) begin
      send_coord(probe_table[i].row, probe_table[i].col,
                 probe_table[i].typed ? probe_table[i].cls
                                      : predict_terrain(probe_table[i].row, probe_table[i].col));
      pause_sender(($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
    end

    sent    = 0;
    drained = 1'b0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst; k++) begin
        sr = coord_sample($urandom_range(0, 9));
        sc = coord_sample($urandom_range(0, 9));
        send_coord(sr, sc, predict_terrain(sr, sc));
        sent++;
      end
      if (!drained && sent >= RandomItems / 2) begin
        // hold off until the pipeline has emptied
        in_valid <= 1'b0;
        while (pending_terrain.size() > 0) @(posedge clk);
        drained = 1'b1;
      end else begin
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
    end

    in_valid <= 1'b0;
    while (pending_terrain.size() > 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (pending_terrain.size() > 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_terrain.size()));
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
